>>> rtl/tssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tssm_pkg;

    // Width of every raw reading, window register and screen coordinate.
    localparam int FIELD_W     = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int AVG_BITS    = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] SAMPLE_MASK = FIELD_W'((64'(1) << AVG_BITS) - 64'(1));

    localparam int MODE_W   = 4;
    localparam int CFG_IDX_W = 3;

    // Restoring divider: two quotient bits per stage.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = FIELD_W / DIV_BITS_PER_STAGE;
    localparam int PROD_W             = 2 * FIELD_W;

    // Front end has two stages, each axis unit one multiply stage plus the divider.
    localparam int FRONT_DEPTH = 2;
    localparam int AXIS_DEPTH  = 1 + DIV_STAGES;
    localparam int PIPE_DEPTH  = FRONT_DEPTH + AXIS_DEPTH;

    localparam logic [FIELD_W-1:0] RST_RAW_MIN_X = FIELD_W'(180);
    localparam logic [FIELD_W-1:0] RST_RAW_MAX_X = FIELD_W'(3900);
    localparam logic [FIELD_W-1:0] RST_RAW_MIN_Y = FIELD_W'(220);
    localparam logic [FIELD_W-1:0] RST_RAW_MAX_Y = FIELD_W'(3900);
    localparam logic [FIELD_W-1:0] RST_SCREEN_W  = FIELD_W'(320);
    localparam logic [FIELD_W-1:0] RST_SCREEN_H  = FIELD_W'(240);
    localparam logic [FIELD_W-1:0] RST_PRESS_THR = FIELD_W'(20);
    localparam logic [MODE_W-1:0]  RST_MODE      = '0;

    localparam int MODE_REQ_PRESS = 0;
    localparam int MODE_SWAP      = 1;
    localparam int MODE_INV_X     = 2;
    localparam int MODE_INV_Y     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_MIN_X = 3'd0,
        REG_RAW_MAX_X = 3'd1,
        REG_RAW_MIN_Y = 3'd2,
        REG_RAW_MAX_Y = 3'd3,
        REG_SCREEN_W  = 3'd4,
        REG_SCREEN_H  = 3'd5,
        REG_PRESS_THR = 3'd6,
        REG_MODE      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MAP_ZERO = 2'd0,
        MAP_TOP  = 2'd1,
        MAP_DIV  = 2'd2
    } t_map_sel;

    typedef struct packed {
        logic [FIELD_W-1:0] raw_min_x;
        logic [FIELD_W-1:0] raw_max_x;
        logic [FIELD_W-1:0] raw_min_y;
        logic [FIELD_W-1:0] raw_max_y;
        logic [FIELD_W-1:0] screen_w;
        logic [FIELD_W-1:0] screen_h;
        logic [FIELD_W-1:0] press_thr;
        logic [MODE_W-1:0]  mode;
    } t_cfg;

    typedef struct packed {
        t_map_sel           sel;
        logic [FIELD_W-1:0] diff;
        logic [FIELD_W-1:0] den;
        logic [FIELD_W-1:0] top;
    } t_axis_job;

    function automatic logic [FIELD_W-1:0] avg_pair(input logic [FIELD_W-1:0] a,
                                                    input logic [FIELD_W-1:0] b);
        logic [FIELD_W:0] s;
        s = {1'b0, a & SAMPLE_MASK} + {1'b0, b & SAMPLE_MASK};
        return s[FIELD_W:1];
    endfunction

    function automatic logic [FIELD_W-1:0] size_top(input logic [FIELD_W-1:0] size);
        return (size == '0) ? '0 : size - FIELD_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/tssm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tssm_front
    import tssm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_cfg               i_cfg,
    input  wire logic [FIELD_W-1:0] i_x_first,
    input  wire logic [FIELD_W-1:0] i_x_second,
    input  wire logic [FIELD_W-1:0] i_y_first,
    input  wire logic [FIELD_W-1:0] i_y_second,
    input  wire logic [FIELD_W-1:0] i_z_first,
    input  wire logic [FIELD_W-1:0] i_z_second,
    input  wire logic               i_z_read_ok,
    output logic                    o_found,
    output logic [FIELD_W-1:0]      o_pressure,
    output t_axis_job               o_job_x,
    output t_axis_job               o_job_y
);

    logic [FIELD_W-1:0] r_ax, r_ay, r_az;
    logic               r_zok;

    logic               r_found, n_found;
    logic [FIELD_W-1:0] r_pressure;
    t_axis_job          r_job_x, n_job_x;
    t_axis_job          r_job_y, n_job_y;
    logic [FIELD_W-1:0] cx, cy;

    function automatic t_axis_job make_job(input logic [FIELD_W-1:0] raw,
                                           input logic [FIELD_W-1:0] lo,
                                           input logic [FIELD_W-1:0] hi,
                                           input logic [FIELD_W-1:0] size);
        t_axis_job j;
        j.top  = size_top(size);
        j.diff = raw - lo;
        j.den  = hi - lo;
        // The minimum clamp wins over the maximum clamp on a reversed window.
        if (raw <= lo) begin
            j.sel = MAP_ZERO;
        end else if (raw >= hi) begin
            j.sel = MAP_TOP;
        end else begin
            j.sel = MAP_DIV;
        end
        return j;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= avg_pair(i_x_first, i_x_second);
            r_ay  <= avg_pair(i_y_first, i_y_second);
            r_az  <= i_z_read_ok ? avg_pair(i_z_first, i_z_second) : '0;
            r_zok <= i_z_read_ok;
        end
    end

    always_comb begin
        n_found = (r_ax >= i_cfg.raw_min_x) && (r_ax <= i_cfg.raw_max_x) &&
                  (r_ay >= i_cfg.raw_min_y) && (r_ay <= i_cfg.raw_max_y);
        if (i_cfg.mode[MODE_REQ_PRESS] && r_zok && (r_az < i_cfg.press_thr)) begin
            n_found = 1'b0;
        end
        if (i_cfg.mode[MODE_SWAP]) begin
            cx = r_ay;
            cy = r_ax;
        end else begin
            cx = r_ax;
            cy = r_ay;
        end
        n_job_x = make_job(cx, i_cfg.raw_min_x, i_cfg.raw_max_x, i_cfg.screen_w);
        n_job_y = make_job(cy, i_cfg.raw_min_y, i_cfg.raw_max_y, i_cfg.screen_h);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_found    <= n_found;
            r_pressure <= r_az;
            r_job_x    <= n_job_x;
            r_job_y    <= n_job_y;
        end
    end

    assign o_found    = r_found;
    assign o_pressure = r_pressure;
    assign o_job_x    = r_job_x;
    assign o_job_y    = r_job_y;

endmodule

`default_nettype wire

>>> rtl/tssm_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module tssm_axis
    import tssm_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire t_axis_job     i_job,
    output logic [FIELD_W-1:0] o_coord
);

    // Multiply stage.
    logic [PROD_W-1:0]  r_prod;
    t_map_sel           r_msel;
    logic [FIELD_W-1:0] r_mden;
    logic [FIELD_W-1:0] r_mtop;

    // Divider stages.
    logic [FIELD_W-1:0] r_rem [DIV_STAGES];
    logic [FIELD_W-1:0] r_low [DIV_STAGES];
    logic [FIELD_W-1:0] r_quo [DIV_STAGES];
    logic [FIELD_W-1:0] r_den [DIV_STAGES];
    logic [FIELD_W-1:0] r_top [DIV_STAGES];
    t_map_sel           r_sel [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_job.diff) * PROD_W'(i_job.top);
            r_msel <= i_job.sel;
            r_mden <= i_job.den;
            r_mtop <= i_job.top;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [FIELD_W-1:0] rem_in, low_in, quo_in, den_in, top_in;
        logic [FIELD_W-1:0] n_rem, n_low, n_quo;
        t_map_sel           sel_in;
        logic [FIELD_W:0]   trial;

        // The quotient stays below the screen size, so the high half of the
        // product is already a valid partial remainder.
        if (k == 0) begin : g_first
            assign rem_in = r_prod[PROD_W-1:FIELD_W];
            assign low_in = r_prod[FIELD_W-1:0];
            assign quo_in = '0;
            assign den_in = r_mden;
            assign top_in = r_mtop;
            assign sel_in = r_msel;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign top_in = r_top[k-1];
            assign sel_in = r_sel[k-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_low = low_in;
            n_quo = quo_in;
            trial = '0;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                trial = {n_rem, n_low[FIELD_W-1]};
                n_low = {n_low[FIELD_W-2:0], 1'b0};
                if (trial >= {1'b0, den_in}) begin
                    trial = trial - {1'b0, den_in};
                    n_quo = {n_quo[FIELD_W-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[FIELD_W-2:0], 1'b0};
                end
                n_rem = trial[FIELD_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= n_low;
                r_quo[k] <= n_quo;
                r_den[k] <= den_in;
                r_top[k] <= top_in;
                r_sel[k] <= sel_in;
            end
        end
    end

    always_comb begin
        unique case (r_sel[DIV_STAGES-1])
            MAP_ZERO: o_coord = '0;
            MAP_TOP:  o_coord = r_top[DIV_STAGES-1];
            MAP_DIV:  o_coord = r_quo[DIV_STAGES-1];
            default:  o_coord = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/touch_sample_to_screen_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_x_first .. i_z_second, i_z_read_ok
// output    out        o_out_valid / i_out_stall o_status, o_screen_x, o_screen_y, o_pressure
// config    in         i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One item is accepted per cycle while o_in_stall is low; its result is shown
// once it has passed ten register stages (two front stages, a multiply stage,
// six divider stages of two quotient bits each, and the output register).
// Synchronous active-low reset empties the pipeline and loads the default
// calibration. A stalled output freezes the whole pipeline, so the input is
// stalled only while a result waits at the output.

module touch_sample_to_screen_map
    import tssm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FIELD_W-1:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [FIELD_W-1:0]   i_x_first,
    input  wire logic [FIELD_W-1:0]   i_x_second,
    input  wire logic [FIELD_W-1:0]   i_y_first,
    input  wire logic [FIELD_W-1:0]   i_y_second,
    input  wire logic [FIELD_W-1:0]   i_z_first,
    input  wire logic [FIELD_W-1:0]   i_z_second,
    input  wire logic                 i_z_read_ok,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_status,
    output logic [FIELD_W-1:0]        o_screen_x,
    output logic [FIELD_W-1:0]        o_screen_y,
    output logic [FIELD_W-1:0]        o_pressure
);

    t_cfg r_cfg;

    logic en;
    logic r_vld [PIPE_DEPTH];

    logic               front_found;
    logic [FIELD_W-1:0] front_pressure;
    t_axis_job          job_x, job_y;
    logic [FIELD_W-1:0] coord_x, coord_y;

    logic               r_side_found [AXIS_DEPTH];
    logic [FIELD_W-1:0] r_side_press [AXIS_DEPTH];

    logic               r_out_valid;
    logic               r_status;
    logic [FIELD_W-1:0] r_sx, r_sy, r_press;
    logic [FIELD_W-1:0] n_sx, n_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_min_x <= RST_RAW_MIN_X;
            r_cfg.raw_max_x <= RST_RAW_MAX_X;
            r_cfg.raw_min_y <= RST_RAW_MIN_Y;
            r_cfg.raw_max_y <= RST_RAW_MAX_Y;
            r_cfg.screen_w  <= RST_SCREEN_W;
            r_cfg.screen_h  <= RST_SCREEN_H;
            r_cfg.press_thr <= RST_PRESS_THR;
            r_cfg.mode      <= RST_MODE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_RAW_MIN_X: r_cfg.raw_min_x <= i_cfg_data;
                REG_RAW_MAX_X: r_cfg.raw_max_x <= i_cfg_data;
                REG_RAW_MIN_Y: r_cfg.raw_min_y <= i_cfg_data;
                REG_RAW_MAX_Y: r_cfg.raw_max_y <= i_cfg_data;
                REG_SCREEN_W:  r_cfg.screen_w  <= i_cfg_data;
                REG_SCREEN_H:  r_cfg.screen_h  <= i_cfg_data;
                REG_PRESS_THR: r_cfg.press_thr <= i_cfg_data;
                REG_MODE:      r_cfg.mode      <= i_cfg_data[MODE_W-1:0];
                default:       r_cfg.mode      <= r_cfg.mode;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register can take a result.
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[PIPE_DEPTH-1];
        end
    end

    tssm_front u_front (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_cfg       (r_cfg),
        .i_x_first   (i_x_first),
        .i_x_second  (i_x_second),
        .i_y_first   (i_y_first),
        .i_y_second  (i_y_second),
        .i_z_first   (i_z_first),
        .i_z_second  (i_z_second),
        .i_z_read_ok (i_z_read_ok),
        .o_found     (front_found),
        .o_pressure  (front_pressure),
        .o_job_x     (job_x),
        .o_job_y     (job_y)
    );

    tssm_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_job   (job_x),
        .o_coord (coord_x)
    );

    tssm_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_job   (job_y),
        .o_coord (coord_y)
    );

    // Touch flag and pressure ride alongside the axis units.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_found[0] <= front_found;
            r_side_press[0] <= front_pressure;
            for (int k = 1; k < AXIS_DEPTH; k++) begin
                r_side_found[k] <= r_side_found[k-1];
                r_side_press[k] <= r_side_press[k-1];
            end
        end
    end

    always_comb begin
        n_sx = coord_x;
        n_sy = coord_y;
        if (r_cfg.mode[MODE_INV_X]) begin
            n_sx = (r_cfg.screen_w == '0) ? '0 : size_top(r_cfg.screen_w) - coord_x;
        end
        if (r_cfg.mode[MODE_INV_Y]) begin
            n_sy = (r_cfg.screen_h == '0) ? '0 : size_top(r_cfg.screen_h) - coord_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_side_found[AXIS_DEPTH-1]) begin
                r_status <= 1'b0;
                r_sx     <= n_sx;
                r_sy     <= n_sy;
                r_press  <= r_side_press[AXIS_DEPTH-1];
            end else begin
                r_status <= 1'b1;
                r_sx     <= '0;
                r_sy     <= '0;
                r_press  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_screen_x  = r_sx;
    assign o_screen_y  = r_sy;
    assign o_pressure  = r_press;

    a_no_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_screen_x == '0 && o_screen_y == '0 && o_pressure == '0)
        else $error("no-touch result carries non-zero fields");

    a_stall_only_when_full: assert property (@(posedge i_clk)
        o_in_stall |-> o_out_valid)
        else $error("input stalled while output register is empty");

    a_last_stage_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_vld[PIPE_DEPTH-1] |=> o_out_valid)
        else $error("item lost between last stage and output register");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
